// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Clocked check whose expression may never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// ===== src/pfe_pkg.sv =====
`default_nettype none

package pfe_pkg;

	localparam int CELL_W = 5;
	localparam int SIDE = 5;
	localparam int CELLS = SIDE * SIDE;
	localparam int KEY_BITS = CELLS * CELL_W;
	localparam int KEY_PART_W = 60;
	localparam int CFG_DATA_W = KEY_PART_W;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LAST = 2'd2;

	localparam logic [7:0] FILL_LETTER = 8'h78;
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [6:0] CIPHER_BASE = 7'h41;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [6:0] cipher_first;
		logic [6:0] cipher_second;
		logic       last_pair;
		logic       bad_letter;
	} out_item_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic       last;
	} pair_t;

	typedef struct packed {
		logic  first_valid;
		logic  second_valid;
		pair_t first_pair;
		pair_t second_pair;
	} pair_push_t;

	typedef struct packed {
		logic              head_valid;
		logic              stall;
		logic [QCNT_W-1:0] count;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== src/pfe_pairing.sv =====
`default_nettype none

module pfe_pairing (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire pfe_pkg::in_item_t item,
	output pfe_pkg::pair_push_t    push
);
	import pfe_pkg::*;

	logic [7:0] pending_q;
	logic       pending_valid_q;
	logic [7:0] pending_d;
	logic       pending_valid_d;
	logic [7:0] ch;
	logic       eom;

	assign ch = item.char_code;
	assign eom = item.end_of_message;

	always_comb begin
		push = '0;
		pending_d = pending_q;
		pending_valid_d = pending_valid_q;
		if (ch == SPACE_CODE) begin
			if (eom && pending_valid_q) begin
				push.first_valid = 1'b1;
				push.first_pair = '{first: pending_q, second: FILL_LETTER, last: 1'b1};
				pending_valid_d = 1'b0;
				pending_d = '0;
			end
		end else if (!pending_valid_q) begin
			if (eom) begin
				push.first_valid = 1'b1;
				push.first_pair = '{first: ch, second: FILL_LETTER, last: 1'b1};
			end else begin
				pending_d = ch;
				pending_valid_d = 1'b1;
			end
		end else if (ch == pending_q) begin
			// doubled letter: split with filler
			push.first_valid = 1'b1;
			push.first_pair = '{first: pending_q, second: FILL_LETTER, last: 1'b0};
			if (eom) begin
				push.second_valid = 1'b1;
				push.second_pair = '{first: ch, second: FILL_LETTER, last: 1'b1};
				pending_valid_d = 1'b0;
				pending_d = '0;
			end
		end else begin
			push.first_valid = 1'b1;
			push.first_pair = '{first: pending_q, second: ch, last: eom};
			pending_valid_d = 1'b0;
			pending_d = '0;
		end
		if (!accept) begin
			push.first_valid = 1'b0;
			push.second_valid = 1'b0;
			pending_d = pending_q;
			pending_valid_d = pending_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			pending_valid_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			pending_valid_q <= pending_valid_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/pfe_pair_queue.sv =====
`default_nettype none

module pfe_pair_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pfe_pkg::pair_push_t push,
	input  wire logic                pop,
	output pfe_pkg::pair_t           head,
	output pfe_pkg::queue_status_t   status
);
	import pfe_pkg::*;

	pair_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_next;
	logic [QCNT_W-1:0] push_cnt;
	logic [QCNT_W-1:0] pop_cnt;

	assign wr_next = wr_ptr_q + QPTR_W'(1);
	assign push_cnt = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);
	assign pop_cnt = QCNT_W'(pop);

	assign head = entry_q[rd_ptr_q];
	assign status.head_valid = (count_q != '0);
	// room for a full two-pair transfer
	assign status.stall = (count_q > QCNT_W'(QUEUE_DEPTH - 2));
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			entry_q[wr_ptr_q] <= push.first_pair;
		end
		if (push.second_valid) begin
			entry_q[wr_next] <= push.second_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + push_cnt - pop_cnt;
		end
	end

endmodule

`default_nettype wire

// ===== src/pfe_encoder.sv =====
`default_nettype none

module pfe_encoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [pfe_pkg::KEY_BITS-1:0]    key_cells,
	input  wire logic                            head_valid,
	input  wire pfe_pkg::pair_t                  head,
	input  wire logic                            out_stall,
	output logic                                 pop,
	output logic                                 out_valid,
	output pfe_pkg::out_item_t                   out_item
);
	import pfe_pkg::*;

	logic [CELLS-1:0]  hit_a;
	logic [CELLS-1:0]  hit_b;
	logic [CELLS-1:0]  sel_a;
	logic [CELLS-1:0]  sel_b;
	logic [7:0]        diff_a;
	logic [7:0]        diff_b;
	logic              in_a;
	logic              in_b;
	logic [SIDE-1:0]   row_a;
	logic [SIDE-1:0]   col_a;
	logic [SIDE-1:0]   row_b;
	logic [SIDE-1:0]   col_b;
	logic [SIDE-1:0]   row_p;
	logic [SIDE-1:0]   col_p;
	logic [SIDE-1:0]   row_q;
	logic [SIDE-1:0]   col_q;
	logic [CELL_W-1:0] val_p;
	logic [CELL_W-1:0] val_q;
	logic              bad;
	out_item_t         result;
	logic              out_valid_q;
	out_item_t         out_item_q;

	assign diff_a = head.first - LOWER_A;
	assign diff_b = head.second - LOWER_A;

	always_comb begin
		in_a = head.first inside {[LOWER_A:LOWER_Z]};
		in_b = head.second inside {[LOWER_A:LOWER_Z]};
		for (int n = 0; n < CELLS; n++) begin
			hit_a[n] = in_a && (key_cells[n*CELL_W +: CELL_W] == diff_a[CELL_W-1:0]);
			hit_b[n] = in_b && (key_cells[n*CELL_W +: CELL_W] == diff_b[CELL_W-1:0]);
		end
		// lowest matching cell wins
		sel_a = hit_a & (~hit_a + CELLS'(1));
		sel_b = hit_b & (~hit_b + CELLS'(1));
		col_a = '0;
		col_b = '0;
		for (int r = 0; r < SIDE; r++) begin
			row_a[r] = |sel_a[r*SIDE +: SIDE];
			row_b[r] = |sel_b[r*SIDE +: SIDE];
			for (int c = 0; c < SIDE; c++) begin
				col_a[c] = col_a[c] | sel_a[r*SIDE + c];
				col_b[c] = col_b[c] | sel_b[r*SIDE + c];
			end
		end
		bad = !(|hit_a) || !(|hit_b);

		// one-hot rotate left = step with wrap
		if (row_a == row_b) begin
			row_p = row_a;
			col_p = {col_a[SIDE-2:0], col_a[SIDE-1]};
			row_q = row_b;
			col_q = {col_b[SIDE-2:0], col_b[SIDE-1]};
		end else if (col_a == col_b) begin
			row_p = {row_a[SIDE-2:0], row_a[SIDE-1]};
			col_p = col_a;
			row_q = {row_b[SIDE-2:0], row_b[SIDE-1]};
			col_q = col_b;
		end else begin
			row_p = row_a;
			col_p = col_b;
			row_q = row_b;
			col_q = col_a;
		end

		val_p = '0;
		val_q = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				val_p = val_p | ({CELL_W{row_p[r] & col_p[c]}}
					& key_cells[(r*SIDE + c)*CELL_W +: CELL_W]);
				val_q = val_q | ({CELL_W{row_q[r] & col_q[c]}}
					& key_cells[(r*SIDE + c)*CELL_W +: CELL_W]);
			end
		end

		result.last_pair = head.last;
		result.bad_letter = bad;
		if (bad) begin
			result.cipher_first = '0;
			result.cipher_second = '0;
		end else begin
			result.cipher_first = CIPHER_BASE + {2'b00, val_p};
			result.cipher_second = CIPHER_BASE + {2'b00, val_q};
		end
	end

	assign pop = head_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

`default_nettype wire

// ===== src/playfair_encrypt_stream_unit.sv =====
// A result is held first in a four-entry pair queue, then in the output register.
// Throughput: one character per cycle while in_stall is low; a doubled letter that
// ends a message yields two results, drained one per cycle while out_stall is low.
// Input stall rises while the queue has fewer than two free entries.
// Reset clears the key square, the pending letter, the queue and the output valid.
`default_nettype none

`include "assert_macros.svh"

module playfair_encrypt_stream_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [pfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [pfe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire pfe_pkg::in_item_t                  in_item,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output pfe_pkg::out_item_t                      out_item
);
	import pfe_pkg::*;

	logic [KEY_PART_W-1:0] key_low_q;
	logic [KEY_PART_W-1:0] key_high_q;
	logic [CELL_W-1:0]     key_last_q;
	logic [KEY_BITS-1:0]   key_cells;
	logic                  accept;
	pair_push_t            push;
	pair_t                 head;
	queue_status_t         qstat;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_last_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_KEY_LOW: key_low_q <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LAST: key_last_q <= cfg_data[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	assign key_cells = {key_last_q, key_high_q, key_low_q};
	assign in_stall = qstat.stall;
	assign accept = in_valid && !qstat.stall;

	pfe_pairing u_pairing (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.push   (push)
	);

	pfe_pair_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.status (qstat)
	);

	pfe_encoder u_encoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_cells  (key_cells),
		.head_valid (qstat.head_valid),
		.head       (head),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_item   (out_item)
	);

	`ASSERT_CLK(a_second_needs_first, clk, arst_n,
		push.second_valid |-> push.first_valid, "second pair pushed without first")
	`ASSERT_CLK(a_queue_bound, clk, arst_n,
		qstat.count <= QCNT_W'(QUEUE_DEPTH), "pair queue overflow")
	`ASSERT_CLK(a_bad_zero, clk, arst_n,
		out_valid && out_item.bad_letter |->
		out_item.cipher_first == '0 && out_item.cipher_second == '0,
		"bad letter result carries cipher text")
	`ASSERT_CLK(a_drain, clk, arst_n,
		qstat.head_valid && !out_valid |=> out_valid, "queued pair not moved to output")

endmodule

`default_nettype wire
